// ===== hw/rtl/dcc_pkg.sv =====
// Shared types, widths and codes for the dependency cycle checker.
package dcc_pkg;

   localparam int MAX_NODES_DEFAULT = 16;
   localparam int DEP_W             = 16;
   localparam int STATUS_W          = 2;
   localparam int NODE_COUNT_W      = 5;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACYCLIC    = 2'd0,
      STATUS_CYCLE      = 2'd1,
      STATUS_UNRESOLVED = 2'd2,
      STATUS_OVERFLOW   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MASK,
      ST_STEP,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic mask;
      logic step;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic step_last;
   } stat_type;

endpackage

// ===== hw/rtl/dcc_datapath.sv =====
// Row store, counters, Warshall closure update and verdict register.
module dcc_datapath #(
   parameter int MAX_NODES = dcc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dcc_pkg::cmd_type                   cmd,
   output dcc_pkg::stat_type                  stat,
   input  logic [dcc_pkg::DEP_W-1:0]          dep_mask,
   input  logic                               type_resolved,
   output logic [dcc_pkg::STATUS_W-1:0]       status,
   output logic [dcc_pkg::NODE_COUNT_W-1:0]   node_count
);
   import dcc_pkg::*;

   // Only the first DEP_W rows can ever take part in a cycle
   localparam int ROWS  = (MAX_NODES < DEP_W) ? MAX_NODES : DEP_W;
   localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);

   logic [DEP_W-1:0]        row_ff [ROWS];
   logic [DEP_W-1:0]        row_in [ROWS];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    unresolved_ff, unresolved_in;
   logic                    overflow_ff, overflow_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [NODE_COUNT_W-1:0] count_ff, count_in;

   logic [CNT_W-1:0]        limit;
   logic [CNT_W-1:0]        k_ext;
   logic [DEP_W-1:0]        keep;
   logic [DEP_W-1:0]        sel;
   logic [DEP_W-1:0]        row_k;
   logic                    cyc;
   status_type              verdict;

   always_comb begin
      limit = (cnt_ff > CNT_W'(ROWS)) ? CNT_W'(ROWS) : cnt_ff;
      k_ext = CNT_W'(k_ff);
      sel   = DEP_W'(1) << k_ff;
      row_k = row_ff[k_ff];
      for (int j = 0; j < DEP_W; j++) begin
         keep[j] = (32'(cnt_ff) > j);
      end
      cyc = 1'b0;
      for (int i = 0; i < ROWS; i++) begin
         if (row_ff[i][i] && (32'(limit) > i)) begin
            cyc = 1'b1;
         end
      end
      if (overflow_ff) begin
         verdict = STATUS_OVERFLOW;
      end else if (unresolved_ff) begin
         verdict = STATUS_UNRESOLVED;
      end else if (cyc) begin
         verdict = STATUS_CYCLE;
      end else begin
         verdict = STATUS_ACYCLIC;
      end
      stat.step_last = ((k_ext + CNT_W'(1)) == limit);
   end

   always_comb begin
      row_in        = row_ff;
      cnt_in        = cnt_ff;
      unresolved_in = unresolved_ff;
      overflow_in   = overflow_ff;
      k_in          = k_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      if (cmd.load) begin
         if (cnt_ff < CNT_W'(MAX_NODES)) begin
            if (cnt_ff < CNT_W'(ROWS)) begin
               row_in[cnt_ff[IDX_W-1:0]] = dep_mask;
            end
            if (!type_resolved) begin
               unresolved_in = 1'b1;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.mask) begin
         // drop references beyond the node count
         for (int i = 0; i < ROWS; i++) begin
            row_in[i] = row_ff[i] & keep;
         end
         k_in = '0;
      end
      if (cmd.step) begin
         // every row that reaches node k also reaches what k reaches
         for (int i = 0; i < ROWS; i++) begin
            if ((row_ff[i] & sel) != '0) begin
               row_in[i] = row_ff[i] | row_k;
            end
         end
         k_in = k_ff + IDX_W'(1);
      end
      if (cmd.publish) begin
         status_in     = verdict;
         count_in      = NODE_COUNT_W'(cnt_ff);
         cnt_in        = '0;
         unresolved_in = 1'b0;
         overflow_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      count_ff  <= count_in;
      if (reset) begin
         cnt_ff        <= '0;
         unresolved_ff <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         unresolved_ff <= unresolved_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign status     = status_ff;
   assign node_count = count_ff;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_NODES))
      else $error("row count beyond node limit");
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (cnt_ff == CNT_W'(MAX_NODES)))
      else $error("overflow flagged with row store not full");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (k_ext < limit))
      else $error("closure pivot beyond loaded rows");
`endif

endmodule

// ===== hw/rtl/dcc_ctrl.sv =====
// Controller state machine: row loading, closure sequencing and result hand-off.
module dcc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dcc_pkg::cmd_type  cmd,
   input  dcc_pkg::stat_type stat
);
   import dcc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      accept      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            accept    = req_valid;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            cmd.mask = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (stat.step_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("verdict overwrites a result not yet taken");
   a_last_starts_closure: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (state_ff == ST_MASK))
      else $error("last row did not start the closure");
   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the verdict state");
`endif

endmodule

// ===== hw/rtl/dependency_cycle_check.sv =====
// Top level of the dependency cycle checker: controller plus datapath.
//
//   channel | prefix | direction | beat carries
//   --------+--------+-----------+-------------------------------------------
//   request | req_   | in        | dep_mask, type_resolved, last (one node row)
//   result  | rsp_   | out       | status, node_count (one verdict per schema)
//
// A new row can be taken every cycle in the load state, never in the others.
// A last row is loaded, then the rows are masked to the node count, then one
// closure step runs per loaded row up to ROWS (one Warshall pivot per cycle
// over the row registers), and the verdict is handed off once the result is free.
// Reset is synchronous and active high; it clears the row count, the flags
// and the result valid. The row store needs no clearing.
// The verdict sits in an output register, so rows of the next schema are
// taken while it waits; a stalled result only holds a further verdict.
module dependency_cycle_check #(
   parameter int MAX_NODES = dcc_pkg::MAX_NODES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dcc_pkg::DEP_W-1:0]         req_dep_mask,
   input  logic                              req_type_resolved,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dcc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dcc_pkg::NODE_COUNT_W-1:0]  rsp_node_count
);
   import dcc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence loads, the closure pass and the verdict hand-off
   dcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Hold the rows, advance the closure and register the verdict
   dcc_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .dep_mask      (req_dep_mask),
      .type_resolved (req_type_resolved),
      .status        (rsp_status),
      .node_count    (rsp_node_count)
   );

endmodule
